// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the LED blink controller RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge while out of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mlb_pkg.sv =====
// Package for the multi-LED blink controller: sizes, codes, word types.
// No dependencies.
`default_nettype none

package mlb_pkg;

    localparam int LED_COUNT = 8;
    localparam int IDX_W     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    // LEDs that show up in the pin mask
    localparam int PIN_LEDS  = (LED_COUNT < 8) ? LED_COUNT : 8;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_SET   = 2'd1,
        MODE_FLASH = 2'd2,
        MODE_READ  = 2'd3
    } mode_t;

    // status / end action codes
    localparam logic [1:0] ST_OFF    = 2'd0;
    localparam logic [1:0] ST_ON     = 2'd1;
    localparam logic [1:0] ST_TOGGLE = 2'd2;

    // read result codes
    localparam logic [1:0] RD_OFF     = 2'd0;
    localparam logic [1:0] RD_ON      = 2'd1;
    localparam logic [1:0] RD_UNKNOWN = 2'd2;

    typedef struct packed {
        mode_t       mode;
        logic [7:0]  led_index;
        logic [1:0]  status_code;
        logic [15:0] period_ticks;
        logic [15:0] on_ticks;
        logic [7:0]  flash_count;
        logic [1:0]  final_status;
    } in_word_t;

    typedef struct packed {
        logic [7:0] pin_levels;
        logic [1:0] read_status;
    } out_word_t;

    // per-LED state; period != 0 means flashing
    typedef struct packed {
        logic [15:0] period;
        logic [15:0] on_time;
        logic [8:0]  flashes;   // 0 endless, else remaining + 1
        logic [15:0] counter;
        logic        lit;
        logic [1:0]  end_act;
    } led_entry_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TICK,
        S_EXEC,
        S_DONE
    } seq_state_t;

    // apply a status action to a level; unknown codes leave it alone
    function automatic logic drive(input logic lit, input logic [1:0] action);
        logic res;
        case (action)
            ST_OFF:    res = 1'b0;
            ST_ON:     res = 1'b1;
            ST_TOGGLE: res = ~lit;
            default:   res = lit;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/multi_led_blink_controller.sv =====
// Top level of the multi-LED blink controller: sequencer and result register.
// Depends on mlb_pkg, mlb_led_unit, mlb_led_store and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Multi-LED blink controller. Each input word is a tick, a set-status, a
// start-flash or a status read; each returns one output word with the pin
// levels of LEDs 0..7 after the command and, for a read, the LED status.
// One update unit serves all LEDs: a tick walks the LEDs one per cycle
// through the tick state and then loads its result in the done state; set,
// flash and read pass through the exec state and then load the result in
// the done state. The input is stalled while a word is being worked on; the
// result register lets a new word start while the previous result waits to
// be taken, and a word that finishes while that result is still stalled
// holds in its last step until the register frees up.
module multi_led_blink_controller (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_stall,
    input  mlb_pkg::in_word_t  in_word,
    output logic               out_valid,
    input  wire                out_stall,
    output mlb_pkg::out_word_t out_word
);
    import mlb_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LED_COUNT - 1);

    seq_state_t       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    in_word_t         cmd_reg, cmd_next;
    logic [1:0]       rd_reg, rd_next;
    out_word_t        out_word_reg, out_word_next;
    logic             out_valid_reg, out_valid_next;

    logic             st_we;
    led_entry_t       st_rdata;
    led_entry_t       st_wdata;
    logic [LED_COUNT-1:0] lit_all;
    logic [7:0]       pins;
    logic             in_range;

    mlb_led_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .we      (st_we),
        .addr    (idx_reg),
        .wdata   (st_wdata),
        .rdata   (st_rdata),
        .lit_all (lit_all)
    );

    mlb_led_unit u_unit (
        .mode (cmd_reg.mode),
        .cmd  (cmd_reg),
        .cur  (st_rdata),
        .nxt  (st_wdata)
    );

    // pin mask covers the first eight LEDs only
    always_comb
    begin
        pins = 8'd0;
        for (int i = 0; i < PIN_LEDS; i++)
        begin
            pins[i] = lit_all[i];
        end
    end

    assign in_range  = (cmd_reg.led_index < 8'(LED_COUNT));
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // sequencer: next state and store control
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cmd_next       = cmd_reg;
        rd_next        = rd_reg;
        out_word_next  = out_word_reg;
        out_valid_next = out_valid_reg && out_stall;
        st_we          = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next = in_word;
                    rd_next  = RD_OFF;
                    if (in_word.mode == MODE_TICK)
                    begin
                        idx_next   = '0;
                        state_next = S_TICK;
                    end
                    else
                    begin
                        idx_next   = in_word.led_index[IDX_W-1:0];
                        state_next = S_EXEC;
                    end
                end
            end
            S_TICK:
            begin
                st_we = 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_EXEC:
            begin
                st_we = in_range && (cmd_reg.mode != MODE_READ);
                if (cmd_reg.mode == MODE_READ)
                begin
                    if (!in_range)
                        rd_next = RD_UNKNOWN;
                    else
                        rd_next = st_rdata.lit ? RD_ON : RD_OFF;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_word_next.pin_levels  = pins;
                    out_word_next.read_status = rd_reg;
                    out_valid_next            = 1'b1;
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        rd_reg       <= rd_next;
        out_word_reg <= out_word_next;
    end

    // checks
    `ASSERT_CLK(a_tick_idx_range, (state_reg != S_TICK) || (idx_reg <= LAST_IDX), "tick index past last LED")
    `ASSERT_NEXT(a_tick_ends, (state_reg == S_TICK) && (idx_reg == LAST_IDX), state_reg == S_DONE, "tick walk did not finish")
    `ASSERT_NEXT(a_accept_leaves_idle, in_valid && !in_stall, (state_reg == S_TICK) || (state_reg == S_EXEC), "accepted word not started")
    `ASSERT_NEXT(a_result_from_done, !out_valid_reg && (state_reg != S_DONE), !out_valid_reg, "result loaded outside done state")

endmodule

`default_nettype wire

// ===== rtl/mlb_led_unit.sv =====
// Shared per-LED update unit: next state of one LED for any command word.
// Depends on mlb_pkg.
`default_nettype none

module mlb_led_unit (
    input  mlb_pkg::mode_t      mode,
    input  mlb_pkg::in_word_t   cmd,
    input  mlb_pkg::led_entry_t cur,
    output mlb_pkg::led_entry_t nxt
);
    import mlb_pkg::*;

    logic [15:0] cnt_inc;
    logic [8:0]  fl_dec;
    logic [8:0]  fl_start;

    assign cnt_inc  = cur.counter + 16'd1;
    assign fl_dec   = cur.flashes - 9'd1;
    assign fl_start = (cmd.flash_count != 8'd0) ? ({1'b0, cmd.flash_count} + 9'd1) : 9'd0;

    always_comb
    begin
        nxt = cur;
        case (mode)
            // one tick step for a flashing LED
            MODE_TICK:
            begin
                if (cur.period != 16'd0)
                begin
                    nxt.counter = cnt_inc;
                    if (cnt_inc == cur.on_time)
                    begin
                        nxt.lit = 1'b0;
                    end
                    else if (cnt_inc >= cur.period)
                    begin
                        if (cur.flashes == 9'd0)
                        begin
                            nxt.counter = 16'd0;
                            nxt.lit     = 1'b1;
                        end
                        else
                        begin
                            nxt.flashes = fl_dec;
                            if (fl_dec == 9'd1)
                            begin
                                nxt.period  = 16'd0;
                                nxt.on_time = 16'd0;
                                nxt.lit     = drive(cur.lit, cur.end_act);
                            end
                            else
                            begin
                                nxt.counter = 16'd0;
                                nxt.lit     = 1'b1;
                            end
                        end
                    end
                end
            end
            // stop flashing, apply level
            MODE_SET:
            begin
                nxt.period = 16'd0;
                nxt.lit    = drive(cur.lit, cmd.status_code);
            end
            // start a flash, or settle to steady off / on
            MODE_FLASH:
            begin
                nxt.counter = 16'd0;
                nxt.period  = 16'd0;
                nxt.on_time = 16'd0;
                nxt.flashes = 9'd0;
                if (cmd.on_ticks == 16'd0)
                begin
                    nxt.lit = 1'b0;
                end
                else if (cmd.on_ticks >= cmd.period_ticks)
                begin
                    nxt.lit = 1'b1;
                end
                else
                begin
                    nxt.flashes = fl_start;
                    nxt.on_time = cmd.on_ticks;
                    nxt.end_act = cmd.final_status;
                    nxt.period  = cmd.period_ticks;
                    nxt.lit     = 1'b1;
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/mlb_led_store.sv =====
// LED state store: one entry per LED, one write and one read port on a shared
// address, plus the level of every LED. Depends on mlb_pkg.
`default_nettype none

module mlb_led_store (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         we,
    input  wire  [mlb_pkg::IDX_W-1:0]   addr,
    input  mlb_pkg::led_entry_t         wdata,
    output mlb_pkg::led_entry_t         rdata,
    output logic [mlb_pkg::LED_COUNT-1:0] lit_all
);
    import mlb_pkg::*;

    led_entry_t entries_reg [LED_COUNT];

    // entry update; reset leaves every LED off and steady
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LED_COUNT; i++)
            begin
                entries_reg[i] <= '0;
            end
        end
        else if (we)
        begin
            entries_reg[addr] <= wdata;
        end
    end

    assign rdata = entries_reg[addr];

    // level of every LED
    always_comb
    begin
        for (int i = 0; i < LED_COUNT; i++)
        begin
            lit_all[i] = entries_reg[i].lit;
        end
    end

endmodule

`default_nettype wire

// ===== test/multi_led_blink_controller_tb.sv =====
// Testbench for multi_led_blink_controller: directed table, then random words,
// checked against written-out values or an in-bench model of the LED blink state.
// Depends on mlb_pkg and the controller RTL.
`timescale 1ns / 1ps

module multi_led_blink_controller_tb;

    import mlb_pkg::*;

    localparam int          CYCLE_LIMIT  = 500000;
    localparam int          RANDOM_WORDS = 1425;
    localparam int          DRAIN_CYCLES = 20;
    // set-status / end action code that leaves the level alone
    localparam logic [1:0]  ST_HOLD      = 2'd3;

    typedef struct {
        in_word_t  word;
        bit        check;
        out_word_t want;
    } stim_row_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_word_t  in_word;
    logic      out_valid;
    logic      out_stall;
    out_word_t out_word;

    // model copy of the per-LED blink state
    logic [15:0] led_period  [LED_COUNT];
    logic [15:0] led_on_time [LED_COUNT];
    logic [8:0]  led_flashes [LED_COUNT];
    logic [15:0] led_counter [LED_COUNT];
    logic        led_lit     [LED_COUNT];
    logic [1:0]  led_end_act [LED_COUNT];

    out_word_t   reports_due[$];
    stim_row_t   directed_rows[$];
    int          error_count = 0;
    int          cycle_count = 0;
    bit          calm_in;
    bit          calm_out = 1'b0;

    multi_led_blink_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // new level after a status action
    function automatic logic apply_status(input logic lit, input logic [1:0] act);
        if (act == ST_OFF)
            return 1'b0;
        else if (act == ST_ON)
            return 1'b1;
        else if (act == ST_TOGGLE)
            return ~lit;
        return lit;
    endfunction

    // advance the model by one input word and return the expected output word
    function automatic out_word_t advance_leds(input in_word_t w);
        out_word_t res;
        int        idx;
        idx = w.led_index;
        res = '0;
        res.read_status = RD_OFF;
        case (w.mode)
            MODE_TICK:
            begin
                for (int i = 0; i < LED_COUNT; i++)
                begin
                    if (led_period[i] != 16'd0)
                    begin
                        led_counter[i] = led_counter[i] + 16'd1;
                        if (led_counter[i] == led_on_time[i])
                            led_lit[i] = 1'b0;
                        else if (led_counter[i] >= led_period[i])
                        begin
                            if (led_flashes[i] == 9'd0)
                            begin
                                // endless flash restarts
                                led_counter[i] = 16'd0;
                                led_lit[i]     = 1'b1;
                            end
                            else
                            begin
                                led_flashes[i] = led_flashes[i] - 9'd1;
                                if (led_flashes[i] == 9'd1)
                                begin
                                    // last flash done: stop and take end state
                                    led_period[i]  = 16'd0;
                                    led_on_time[i] = 16'd0;
                                    led_lit[i]     = apply_status(led_lit[i], led_end_act[i]);
                                end
                                else
                                begin
                                    led_counter[i] = 16'd0;
                                    led_lit[i]     = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            MODE_SET:
            begin
                if (idx < LED_COUNT)
                begin
                    led_period[idx] = 16'd0;
                    led_lit[idx]    = apply_status(led_lit[idx], w.status_code);
                end
            end
            MODE_FLASH:
            begin
                if (idx < LED_COUNT)
                begin
                    led_counter[idx] = 16'd0;
                    led_period[idx]  = 16'd0;
                    led_on_time[idx] = 16'd0;
                    led_flashes[idx] = 9'd0;
                    if (w.on_ticks == 16'd0)
                        led_lit[idx] = 1'b0;
                    else if (w.on_ticks >= w.period_ticks)
                        led_lit[idx] = 1'b1;
                    else
                    begin
                        led_flashes[idx] = (w.flash_count != 8'd0) ?
                                           {1'b0, w.flash_count} + 9'd1 : 9'd0;
                        led_on_time[idx] = w.on_ticks;
                        led_end_act[idx] = w.final_status;
                        led_period[idx]  = w.period_ticks;
                        led_lit[idx]     = 1'b1;
                    end
                end
            end
            default:
            begin
                if (idx < LED_COUNT)
                    res.read_status = led_lit[idx] ? RD_ON : RD_OFF;
                else
                    res.read_status = RD_UNKNOWN;
            end
        endcase
        for (int i = 0; i < PIN_LEDS; i++)
            res.pin_levels[i] = led_lit[i];
        return res;
    endfunction

    // one directed row
    task automatic add_row(input mode_t m, input int idx, input logic [1:0] st,
                           input int per, input int on_t, input int cnt,
                           input logic [1:0] fin, input bit chk,
                           input logic [7:0] pins, input logic [1:0] rd);
        stim_row_t row;
        row.word.mode         = m;
        row.word.led_index    = idx[7:0];
        row.word.status_code  = st;
        row.word.period_ticks = per[15:0];
        row.word.on_ticks     = on_t[15:0];
        row.word.flash_count  = cnt[7:0];
        row.word.final_status = fin;
        row.check             = chk;
        row.want.pin_levels   = pins;
        row.want.read_status  = rd;
        directed_rows.push_back(row);
    endtask

    // present one word after a random gap, wait for accept, queue its result
    task automatic send_word(input in_word_t w, input bit chk, input out_word_t want);
        int        gap;
        out_word_t predicted;
        if ($urandom_range(0, 39) == 0)
            calm_in = !calm_in;
        gap = calm_in ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        predicted = advance_leds(w);
        reports_due.push_back(chk ? want : predicted);
    endtask

    // result side: random stalls, compare each word with the oldest expectation
    initial
    begin
        int        hold;
        out_word_t want;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                calm_out = !calm_out;
            hold = calm_out ? 0 : $urandom_range(0, 8);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
            if (reports_due.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected word pins=%h rd=%0d", $time,
                         out_word.pin_levels, out_word.read_status);
            end
            else
            begin
                want = reports_due.pop_front();
                if (out_word.pin_levels !== want.pin_levels)
                begin
                    error_count++;
                    $display("%0t: pin_levels expected %h actual %h", $time,
                             want.pin_levels, out_word.pin_levels);
                end
                if (out_word.read_status !== want.read_status)
                begin
                    error_count++;
                    $display("%0t: read_status expected %0d actual %0d", $time,
                             want.read_status, out_word.read_status);
                end
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        in_word_t  w;
        out_word_t none;
        int        pick;
        int        per;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_word     = '0;
        calm_in     = 1'b0;
        none        = '0;
        for (int i = 0; i < LED_COUNT; i++)
        begin
            led_period[i]  = '0;
            led_on_time[i] = '0;
            led_flashes[i] = '0;
            led_counter[i] = '0;
            led_lit[i]     = 1'b0;
            led_end_act[i] = '0;
        end

        // reads and steady commands, expected values written out
        add_row(MODE_READ,  0,   ST_OFF,    0,      0,      0,   ST_OFF,    1, 8'h00, RD_OFF);
        add_row(MODE_READ,  255, ST_OFF,    0,      0,      0,   ST_OFF,    1, 8'h00, RD_UNKNOWN);
        add_row(MODE_TICK,  0,   ST_OFF,    0,      0,      0,   ST_OFF,    1, 8'h00, RD_OFF);
        add_row(MODE_SET,   0,   ST_ON,     0,      0,      0,   ST_OFF,    1, 8'h01, RD_OFF);
        add_row(MODE_SET,   7,   ST_ON,     0,      0,      0,   ST_OFF,    1, 8'h81, RD_OFF);
        add_row(MODE_SET,   7,   ST_TOGGLE, 0,      0,      0,   ST_OFF,    1, 8'h01, RD_OFF);
        add_row(MODE_SET,   0,   ST_HOLD,   0,      0,      0,   ST_OFF,    1, 8'h01, RD_OFF);
        add_row(MODE_SET,   8,   ST_ON,     0,      0,      0,   ST_OFF,    1, 8'h01, RD_OFF);
        add_row(MODE_SET,   0,   ST_OFF,    0,      0,      0,   ST_OFF,    1, 8'h00, RD_OFF);
        // zero on-time is steady off, on-time at or past period is steady on
        add_row(MODE_FLASH, 1,   ST_OFF,    65535,  0,      0,   ST_ON,     1, 8'h00, RD_OFF);
        add_row(MODE_FLASH, 2,   ST_OFF,    3,      5,      0,   ST_OFF,    1, 8'h04, RD_OFF);
        add_row(MODE_FLASH, 6,   ST_OFF,    5,      5,      0,   ST_OFF,    1, 8'h44, RD_OFF);
        // counted, endless and longest flashes; out-of-range flash ignored
        add_row(MODE_FLASH, 3,   ST_OFF,    4,      1,      2,   ST_TOGGLE, 1, 8'h4C, RD_OFF);
        add_row(MODE_FLASH, 4,   ST_OFF,    2,      1,      0,   ST_OFF,    1, 8'h5C, RD_OFF);
        add_row(MODE_FLASH, 5,   ST_OFF,    65535,  65534,  255, ST_HOLD,   1, 8'h7C, RD_OFF);
        add_row(MODE_FLASH, 200, ST_ON,     9,      3,      1,   ST_ON,     1, 8'h7C, RD_OFF);
        // run the flashes through their periods
        for (int i = 0; i < 7; i++)
            add_row(MODE_TICK, 0, ST_OFF, 0, 0, 0, ST_OFF, 0, 8'h00, RD_OFF);
        add_row(MODE_SET,   4,   ST_ON,     0,      0,      0,   ST_OFF,    0, 8'h00, RD_OFF);
        add_row(MODE_READ,  3,   ST_OFF,    0,      0,      0,   ST_OFF,    0, 8'h00, RD_OFF);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
            send_word(directed_rows[k].word, directed_rows[k].check, directed_rows[k].want);

        // random words: ticks, sets, reads and flashes that are mostly short, plus full-range noise
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            w.led_index    = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                         : 8'($urandom_range(0, LED_COUNT - 1));
            w.status_code  = 2'($urandom_range(0, 3));
            w.period_ticks = 16'($urandom);
            w.on_ticks     = 16'($urandom);
            w.flash_count  = 8'($urandom);
            w.final_status = 2'($urandom_range(0, 3));
            pick = $urandom_range(0, 99);
            if (pick < 45)
                w.mode = MODE_TICK;
            else if (pick < 65)
            begin
                w.mode = MODE_FLASH;
                if ($urandom_range(0, 7) != 0)
                begin
                    per            = $urandom_range(1, 12);
                    w.period_ticks = 16'(per);
                    w.on_ticks     = 16'($urandom_range(0, per + 1));
                    if ($urandom_range(0, 5) != 0)
                        w.flash_count = 8'($urandom_range(0, 4));
                end
            end
            else if (pick < 80)
                w.mode = MODE_SET;
            else
                w.mode = MODE_READ;
            send_word(w, 1'b0, none);
        end
        in_valid <= 1'b0;

        while (reports_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && reports_due.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== multi_led_blink_controller.f =====
+incdir+rtl
rtl/mlb_pkg.sv
rtl/mlb_led_unit.sv
rtl/mlb_led_store.sv
rtl/multi_led_blink_controller.sv
test/multi_led_blink_controller_tb.sv
